/* design/fqd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package fqd_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int LEN_W     = 5;

  typedef enum logic [1:0] {
    CMD_ENQ = 2'd0,
    CMD_DEQ = 2'd1,
    CMD_DEL = 2'd2,
    CMD_RSV = 2'd3
  } cmd_t;

  typedef struct packed {
    logic occ;
    logic load;
    logic deq;
    logic del;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* design/fqd_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
module fqd_cell (
  input  wire logic                        clk,
  input  wire fqd_pkg::cell_ctrl_t         ctrl,
  input  wire logic [fqd_pkg::DATA_W-1:0]  word,
  input  wire logic [fqd_pkg::DATA_W-1:0]  nbr_data,
  input  wire logic                        found_in,
  output logic                             found_out,
  output logic [fqd_pkg::DATA_W-1:0]       data
);

  logic [fqd_pkg::DATA_W-1:0] data_r;
  logic [fqd_pkg::DATA_W-1:0] data_nxt;
  logic                       hit;

  assign hit       = ctrl.occ && (data_r == word);
  assign found_out = found_in | hit;
  assign data      = data_r;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.deq || (ctrl.del && found_out)) begin
      data_nxt = nbr_data;
    end else if (ctrl.load) begin
      data_nxt = word;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
`default_nettype wire

/* design/fifo_queue_with_delete_core.sv */
// FIFO queue with delete, one command per transfer.
// Input channel (in_valid/in_ready): in_cmd is enqueue, dequeue or delete,
// in_data_in the word to append or to remove; a zero word is rejected.
// Result channel (out_valid/out_ready): out_status (0 ok, 1 fail),
// out_data_out (word removed by a dequeue, else zero), out_length (entries
// held after the command).
// Storage is a row of DEPTH cells, oldest word in cell 0. Every command
// finishes in the cycle it is accepted: each cell compares its word and
// shifts from its right neighbor in parallel, and the match flag ripples
// along the row, so delete is no slower than the others.
// The result is registered and appears in the cycle after the input transfer.
// Throughput: one command per cycle while the result is taken in time.
// When the receiver stalls, the result holds in the output register and
// in_ready drops until it is taken; nothing is lost.
// Reset empties the queue and clears out_valid; it is usable in the next
// cycle with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module fifo_queue_with_delete_core #(
  parameter int DEPTH = fqd_pkg::DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  in_cmd,
  input  wire logic [fqd_pkg::DATA_W-1:0]  in_data_in,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_status,
  output logic [fqd_pkg::DATA_W-1:0]       out_data_out,
  output logic [fqd_pkg::LEN_W-1:0]        out_length
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]                 count_r, count_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_status_r, out_status_nxt;
  logic [fqd_pkg::DATA_W-1:0]    out_data_r, out_data_nxt;
  logic [fqd_pkg::LEN_W-1:0]     out_length_r, out_length_nxt;

  logic                          fire;
  fqd_pkg::cmd_t                 cmd;
  logic                          word_nz;
  logic                          is_enq, is_deq, is_del;
  logic                          enq_ok, deq_ok, del_ok;
  logic [DEPTH:0]                found;
  logic [fqd_pkg::DATA_W-1:0]    cell_data [DEPTH];

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign cmd      = fqd_pkg::cmd_t'(in_cmd);
  assign word_nz  = |in_data_in;
  assign is_enq   = (cmd == fqd_pkg::CMD_ENQ);
  assign is_deq   = (cmd == fqd_pkg::CMD_DEQ);
  assign is_del   = (cmd == fqd_pkg::CMD_DEL);
  assign enq_ok   = fire && is_enq && word_nz && (count_r < CW'(DEPTH));
  assign deq_ok   = fire && is_deq && (count_r != '0);
  assign del_ok   = fire && is_del && word_nz && found[DEPTH];

  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    fqd_pkg::cell_ctrl_t         ctrl;
    logic [fqd_pkg::DATA_W-1:0]  nbr;

    assign ctrl.occ  = (CW'(i) < count_r);
    assign ctrl.load = enq_ok && (CW'(i) == count_r);
    assign ctrl.deq  = deq_ok;
    assign ctrl.del  = del_ok;

    if (i == DEPTH - 1) begin : g_last
      assign nbr = cell_data[i];
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end

    fqd_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .word      (in_data_in),
      .nbr_data  (nbr),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .data      (cell_data[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (enq_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (deq_ok || del_ok) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_length_nxt = out_length_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (fire) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = !(enq_ok || deq_ok || del_ok);
      out_data_nxt   = deq_ok ? cell_data[0] : '0;
      out_length_nxt = fqd_pkg::LEN_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_length_r <= out_length_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data_out = out_data_r;
  assign out_length   = out_length_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue length above depth");

  a_enq_grow: assert property (@(posedge clk) disable iff (!rst_n)
    enq_ok |=> (count_r == $past(count_r) + 1'b1))
    else $error("enqueue did not grow the queue");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_data_r == '0))
    else $error("failed command returned data");

  a_empty_deq: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && is_deq && (count_r == '0)) |=> (out_valid_r && out_status_r))
    else $error("dequeue on empty queue did not fail");

endmodule
`default_nettype wire
